>>> hdl/two_class_partitioned_lru_defines.svh
// Assertion macros for the two-class partitioned LRU block.
`ifndef TWO_CLASS_PARTITIONED_LRU_DEFINES_SVH
`define TWO_CLASS_PARTITIONED_LRU_DEFINES_SVH
`ifndef SYNTH
`define TPL_ASSERT_IMP(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
`define TPL_ASSERT_NXT(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define TPL_ASSERT_IMP(label, clk, rstn, a, c)
`define TPL_ASSERT_NXT(label, clk, rstn, a, c)
`endif
`endif

>>> hdl/tpl_pkg.sv
// ----------------------------------------------------------------------------
// tpl_pkg
// Shared types and codes of the two-class partitioned LRU block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tpl_pkg;
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_TOUCH  = 2'd1;
  localparam logic [1:0] CMD_ERASE  = 2'd2;
  localparam logic [1:0] CLS_IMP    = 2'd0;
  localparam logic [1:0] CLS_OTHER  = 2'd1;

  // Datapath operation selected by the controller for one step.
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_LATCH   = 3'd1;
  localparam logic [2:0] OP_RDLINK  = 3'd2;
  localparam logic [2:0] OP_UNLINK  = 3'd3;
  localparam logic [2:0] OP_APPEND  = 3'd4;
  localparam logic [2:0] OP_VICTIM  = 3'd5;
  localparam logic [2:0] OP_DONE    = 3'd6;

  typedef struct packed {
    logic [2:0] op;
  } tpl_cmd_t;

  typedef struct packed {
    logic valid_item;
    logic is_member;
    logic is_erase;
    logic erase_hit;
    logic is_insert;
    logic evict_go;
  } tpl_stat_t;
endpackage

>>> hdl/tpl_ctrl.sv
// ----------------------------------------------------------------------------
// tpl_ctrl
// Sequencer that steps the datapath through the relink of one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_class_partitioned_lru_defines.svh"
module tpl_ctrl import tpl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  tpl_stat_t stat,
  output tpl_cmd_t  cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_UNL  = 3'd2;
  localparam logic [2:0] S_APP  = 3'd3;
  localparam logic [2:0] S_VRD  = 3'd4;
  localparam logic [2:0] S_VUNL = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;
  localparam logic [2:0] S_URD  = 3'd7;

  logic [2:0] state_r, state_nxt;

  // Next state and the operation for this step.
  always_comb begin
    state_nxt = state_r;
    cmd.op = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LATCH;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (!stat.valid_item) begin
          state_nxt = S_DONE;
        end else if (stat.is_erase) begin
          if (stat.erase_hit) begin
            cmd.op = OP_RDLINK;
            state_nxt = S_URD;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (stat.is_member) begin
          cmd.op = OP_RDLINK;
          state_nxt = S_UNL;
        end else begin
          state_nxt = S_APP;
        end
      end
      S_URD: begin
        cmd.op = OP_UNLINK;
        state_nxt = S_DONE;
      end
      S_UNL: begin
        cmd.op = OP_UNLINK;
        state_nxt = S_APP;
      end
      S_APP: begin
        cmd.op = OP_APPEND;
        state_nxt = stat.is_insert ? S_VRD : S_DONE;
      end
      S_VRD: begin
        if (stat.evict_go) begin
          cmd.op = OP_VICTIM;
          state_nxt = S_VUNL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_VUNL: begin
        cmd.op = OP_UNLINK;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.op = OP_DONE;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  `TPL_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `TPL_ASSERT_NXT(a_done_idle, clk, rst_n, state_r == S_DONE, !busy)
  `TPL_ASSERT_IMP(a_victim_ins, clk, rst_n, state_r == S_VUNL, $past(stat.is_insert))
endmodule

>>> hdl/tpl_dp.sv
// ----------------------------------------------------------------------------
// tpl_dp
// Link memories, list heads and tails, counters and eviction decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_class_partitioned_lru_defines.svh"
module tpl_dp import tpl_pkg::*; #(
  parameter int ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  tpl_cmd_t    cmd,
  output tpl_stat_t   stat,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_entry_id,
  input  logic [1:0]  in_entry_class,
  input  logic [15:0] in_store_count,
  input  logic [15:0] capacity_limit,
  input  logic [15:0] quota_important,
  input  logic [15:0] quota_other,
  output logic        out_strobe,
  output logic        out_evict_valid,
  output logic [7:0]  out_evict_id
);
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = AW + 1;

  logic [AW-1:0] next_mem [ENTRIES];
  logic [AW-1:0] prev_mem [ENTRIES];
  logic [ENTRIES-1:0] member_r;
  logic [ENTRIES-1:0] mclass_r;
  logic [AW-1:0] head_r [2];
  logic [AW-1:0] tail_r [2];
  logic [CW-1:0] count_r [2];

  logic [1:0]    cmd_r;
  logic [7:0]    id_r;
  logic [1:0]    cls_r;
  logic [15:0]   occ_r;
  logic [AW-1:0] tgt_r;
  logic [AW-1:0] np_r, nn_r;
  logic          ev_r;
  logic [AW-1:0] evid_r;
  logic          strobe_r;

  logic          cl;
  logic [AW-1:0] id_s;
  logic          uc;
  logic [15:0]   quota;
  logic [16:0]   cnt_w;
  logic          id_ok;

  assign cl    = cls_r[0];
  assign id_s  = AW'(id_r);
  assign id_ok = ({8'd0, id_r} < 16'(ENTRIES)) || (ENTRIES > 255);
  assign uc    = mclass_r[tgt_r];
  assign quota = cl ? quota_other : quota_important;
  assign cnt_w = 17'(count_r[cl]);

  // Status for the controller.
  always_comb begin
    stat.valid_item = (cls_r <= CLS_OTHER) && (cmd_r <= CMD_ERASE) && id_ok;
    stat.is_member  = member_r[id_s];
    stat.is_erase   = (cmd_r == CMD_ERASE);
    stat.erase_hit  = member_r[id_s] && (mclass_r[id_s] == cl);
    stat.is_insert  = (cmd_r == CMD_INSERT);
    if (occ_r > capacity_limit) begin
      stat.evict_go = cnt_w != 17'd0;
    end else if (occ_r < capacity_limit) begin
      stat.evict_go = (cnt_w != 17'd0) && (cnt_w > {1'b0, quota});
    end else begin
      stat.evict_go = 1'b0;
    end
  end

  // Control state: membership, heads, tails, counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      member_r <= '0;
      mclass_r <= '0;
      head_r[0] <= '0;
      head_r[1] <= '0;
      tail_r[0] <= '0;
      tail_r[1] <= '0;
      count_r[0] <= '0;
      count_r[1] <= '0;
      strobe_r <= 1'b0;
      ev_r <= 1'b0;
    end else begin
      strobe_r <= (cmd.op == OP_DONE);
      case (cmd.op)
        OP_LATCH: ev_r <= 1'b0;
        OP_UNLINK: begin
          if (head_r[uc] == tgt_r) head_r[uc] <= nn_r;
          if (tail_r[uc] == tgt_r) tail_r[uc] <= np_r;
          if (count_r[uc] != '0) count_r[uc] <= count_r[uc] - 1'b1;
          member_r[tgt_r] <= 1'b0;
        end
        OP_APPEND: begin
          if (count_r[cl] == '0) head_r[cl] <= id_s;
          tail_r[cl] <= id_s;
          count_r[cl] <= count_r[cl] + 1'b1;
          member_r[id_s] <= 1'b1;
          mclass_r[id_s] <= cl;
        end
        OP_VICTIM: ev_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // Item fields, target slot, and neighbour links.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        cmd_r <= in_command;
        id_r  <= in_entry_id;
        cls_r <= in_entry_class;
        occ_r <= in_store_count;
      end
      OP_RDLINK: tgt_r <= id_s;
      OP_VICTIM: begin
        tgt_r  <= head_r[cl];
        evid_r <= head_r[cl];
      end
      default: ;
    endcase
    np_r <= prev_mem[(cmd.op == OP_VICTIM) ? head_r[cl] : id_s];
    nn_r <= next_mem[(cmd.op == OP_VICTIM) ? head_r[cl] : id_s];
  end

  // Link memory writes.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_UNLINK) begin
      if (head_r[uc] != tgt_r) next_mem[np_r] <= nn_r;
    end else if (cmd.op == OP_APPEND && count_r[cl] != '0) begin
      next_mem[tail_r[cl]] <= id_s;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.op == OP_UNLINK) begin
      if (tail_r[uc] != tgt_r) prev_mem[nn_r] <= np_r;
    end else if (cmd.op == OP_APPEND && count_r[cl] != '0) begin
      prev_mem[id_s] <= tail_r[cl];
    end
  end

  assign out_strobe      = strobe_r;
  assign out_evict_valid = ev_r;
  assign out_evict_id    = ev_r ? 8'(evid_r) : 8'd0;

  `TPL_ASSERT_IMP(a_ev_id, clk, rst_n, !out_evict_valid, out_evict_id == 8'd0)
  `TPL_ASSERT_NXT(a_unl_clr, clk, rst_n, cmd.op == OP_UNLINK, !member_r[$past(tgt_r)])
  `TPL_ASSERT_NXT(a_app_set, clk, rst_n, cmd.op == OP_APPEND, member_r[$past(id_s)])
endmodule

>>> hdl/two_class_partitioned_lru.sv
// ----------------------------------------------------------------------------
// two_class_partitioned_lru
// Two-class LRU replacement with per-class quotas and eviction choice.
// ----------------------------------------------------------------------------
// Use: raise start with in_command, in_entry_id, in_entry_class and
// in_store_count; the item is taken at a clock edge where busy is low.
// Each item yields one result: out_strobe is high for one cycle with
// out_evict_valid and out_evict_id. The receiver cannot stall.
// The time from acceptance to result depends on the item: shortest for an
// ignored item or an erase that misses, longest for an insert that moves a
// slot and then evicts. It is set by the dependent link memory reads
// and writes of the sequencer. busy drops in the cycle that shows the
// result, so the next item can be taken at the edge that ends it.
// Registers via the APB port: 0 capacity_limit, 1 quota_important,
// 2 quota_other, at byte addresses 0, 4 and 8. Write them only while idle.
// Reset (synchronous, rst_n low) empties both lists and restores the
// register defaults 256, 73 and 10; the link memories need no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module two_class_partitioned_lru import tpl_pkg::*; #(
  parameter int ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_entry_id,
  input  logic [1:0]  in_entry_class,
  input  logic [15:0] in_store_count,
  output logic        out_strobe,
  output logic        out_evict_valid,
  output logic [7:0]  out_evict_id,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam logic [1:0] REG_CAP = 2'd0;
  localparam logic [1:0] REG_QI  = 2'd1;
  localparam logic [1:0] REG_QO  = 2'd2;

  logic [15:0] cap_r, qi_r, qo_r;
  tpl_cmd_t  cmd;
  tpl_stat_t stat;
  logic wr;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 16'd256;
      qi_r  <= 16'd73;
      qo_r  <= 16'd10;
    end else if (wr) begin
      unique case (cfg_paddr[3:2])
        REG_CAP: cap_r <= cfg_pwdata[15:0];
        REG_QI:  qi_r  <= cfg_pwdata[15:0];
        REG_QO:  qo_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_CAP: cfg_prdata = {16'd0, cap_r};
      REG_QI:  cfg_prdata = {16'd0, qi_r};
      REG_QO:  cfg_prdata = {16'd0, qo_r};
      default: cfg_prdata = 32'd0;
    endcase
  end

  tpl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  tpl_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_command(in_command), .in_entry_id(in_entry_id),
    .in_entry_class(in_entry_class), .in_store_count(in_store_count),
    .capacity_limit(cap_r), .quota_important(qi_r), .quota_other(qo_r),
    .out_strobe(out_strobe), .out_evict_valid(out_evict_valid),
    .out_evict_id(out_evict_id)
  );
endmodule
